FILE: hdl/rmma_pkg.sv
// Shared types and constants for the running min/max/average block.
// Used by every module under hdl/; depends on nothing else.
package rmma_pkg;

    // Fixed field widths of the sample and result beats
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned IDX_W    = 17;
    localparam int unsigned AVG_W    = 24;

    // Values reported for an empty set
    localparam logic signed [SAMPLE_W-1:0] EMPTY_VALUE = -16'sd100;
    localparam logic signed [IDX_W-1:0]    EMPTY_INDEX = -17'sd1;

    // Saturation limits of the average
    localparam logic signed [AVG_W-1:0] AVG_SAT_HI = 24'sh7FFFFF;
    localparam logic signed [AVG_W-1:0] AVG_SAT_LO = 24'sh800000;
    localparam int unsigned AVG_HI_MAG = 8388607;
    localparam int unsigned AVG_LO_MAG = 8388608;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_LOAD = 3'b010,
        ST_DIV  = 3'b100
    } t_state;

    // Control from the sequencer to the accumulator
    typedef struct packed {
        logic fold;
        logic clear;
    } t_acc_ctl;

    // Status from the divider
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

FILE: hdl/running_min_max_average.sv
// Top level of the running min/max/average block.
// Depends on rmma_pkg, rmma_accum and rmma_div.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  sample  | in        | i_valid / o_stall  | i_sample, i_last, i_empty_set
//  result  | out       | o_valid / i_stall  | o_min_value, o_min_index, o_max_value,
//          |           |                    | o_max_index, o_average, o_overflow
//
// Samples without last can stream every cycle while o_stall is low.
// An empty-set beat loads the result register directly.
// A last sample takes the sequencer through ST_LOAD and ST_DIV, where the restoring
// divider produces one quotient bit per cycle, DIV_W = SUM_W + FRAC_BITS.
// Reset is synchronous and active low; it clears the sequencer and counters.
// A stalled result holds the output register; o_stall rises only while it is full
// and stalled, or while the sequencer is in ST_LOAD or ST_DIV.
module running_min_max_average import rmma_pkg::*; #(
    parameter int unsigned MAX_ITEMS = 65536,
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_last,
    input  logic                       i_empty_set,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [SAMPLE_W-1:0] o_min_value,
    output logic signed [IDX_W-1:0]    o_min_index,
    output logic signed [SAMPLE_W-1:0] o_max_value,
    output logic signed [IDX_W-1:0]    o_max_index,
    output logic signed [AVG_W-1:0]    o_average,
    output logic                       o_overflow
);

    localparam int unsigned CNT_W   = $clog2(MAX_ITEMS + 1);
    localparam int unsigned SUM_W   = SAMPLE_W + CNT_W;
    localparam int unsigned DIV_W   = SUM_W + FRAC_BITS;
    localparam int unsigned QX_W    = (DIV_W > AVG_W + 1) ? DIV_W : AVG_W + 1;
    localparam int unsigned IDX_X_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam logic signed [AVG_W-1:0] EMPTY_AVG = AVG_W'(-100 * (2 ** FRAC_BITS));

    t_state                     r_state;
    t_state                     n_state;
    t_acc_ctl                   acc_ctl;
    t_div_sts                   div_sts;
    logic [CNT_W-1:0]           acc_count;
    logic signed [SUM_W-1:0]    acc_sum;
    logic signed [SAMPLE_W-1:0] acc_min;
    logic signed [SAMPLE_W-1:0] acc_max;
    logic [CNT_W-1:0]           acc_min_idx;
    logic [CNT_W-1:0]           acc_max_idx;
    logic                       acc_too_many;
    logic [SUM_W-1:0]           sum_mag;
    logic [DIV_W-1:0]           dividend;
    logic [DIV_W-1:0]           quotient;
    logic [QX_W-1:0]            q_x;
    logic [IDX_X_W-1:0]         min_idx_x;
    logic [IDX_X_W-1:0]         max_idx_x;
    logic signed [AVG_W-1:0]    avg;
    logic                       r_neg;
    logic                       r_cnt_zero;
    logic                       in_beat;
    logic                       out_free;
    logic                       load_empty;
    logic                       load_stats;
    logic                       div_start;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_min_value;
    logic signed [IDX_W-1:0]    r_min_index;
    logic signed [SAMPLE_W-1:0] r_max_value;
    logic signed [IDX_W-1:0]    r_max_index;
    logic signed [AVG_W-1:0]    r_average;
    logic                       r_overflow;

    // Handshake
    assign out_free   = !r_out_valid || !i_stall;
    assign o_stall    = (r_state != ST_IDLE) || !out_free;
    assign in_beat    = i_valid && !o_stall;
    assign load_empty = in_beat && i_empty_set;
    assign load_stats = (r_state == ST_DIV) && div_sts.done && out_free;
    assign div_start  = (r_state == ST_LOAD);

    assign acc_ctl.fold  = in_beat && !i_empty_set;
    assign acc_ctl.clear = load_empty || load_stats;

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_beat && !i_empty_set && i_last) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (load_stats) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    rmma_accum #(
        .MAX_ITEMS (MAX_ITEMS),
        .CNT_W     (CNT_W),
        .SUM_W     (SUM_W)
    ) u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (acc_ctl),
        .i_sample   (i_sample),
        .o_count    (acc_count),
        .o_sum      (acc_sum),
        .o_min      (acc_min),
        .o_max      (acc_max),
        .o_min_idx  (acc_min_idx),
        .o_max_idx  (acc_max_idx),
        .o_too_many (acc_too_many)
    );

    // Magnitude of the sum, scaled by the fraction bits
    assign sum_mag  = acc_sum[SUM_W-1] ? SUM_W'(-acc_sum) : SUM_W'(acc_sum);
    assign dividend = DIV_W'(sum_mag) << FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_neg      <= acc_sum[SUM_W-1];
            r_cnt_zero <= (acc_count == '0);
        end
    end

    rmma_div #(
        .DIV_W (DIV_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (acc_count),
        .o_sts      (div_sts),
        .o_quotient (quotient)
    );

    // Sign and saturation of the average
    assign q_x = QX_W'(quotient);
    always_comb begin
        if (r_cnt_zero) begin
            avg = '0;
        end else if (r_neg) begin
            avg = (q_x > QX_W'(AVG_LO_MAG)) ? AVG_SAT_LO : -$signed(q_x[AVG_W-1:0]);
        end else begin
            avg = (q_x > QX_W'(AVG_HI_MAG)) ? AVG_SAT_HI : $signed(q_x[AVG_W-1:0]);
        end
    end

    assign min_idx_x = IDX_X_W'(acc_min_idx);
    assign max_idx_x = IDX_X_W'(acc_max_idx);

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_empty || load_stats) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_empty) begin
            r_min_value <= EMPTY_VALUE;
            r_min_index <= EMPTY_INDEX;
            r_max_value <= EMPTY_VALUE;
            r_max_index <= EMPTY_INDEX;
            r_average   <= EMPTY_AVG;
            r_overflow  <= 1'b0;
        end else if (load_stats) begin
            r_min_value <= acc_min;
            r_min_index <= $signed(min_idx_x[IDX_W-1:0]);
            r_max_value <= acc_max;
            r_max_index <= $signed(max_idx_x[IDX_W-1:0]);
            r_average   <= avg;
            r_overflow  <= acc_too_many;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_min_value = r_min_value;
    assign o_min_index = r_min_index;
    assign o_max_value = r_max_value;
    assign o_max_index = r_max_index;
    assign o_average   = r_average;
    assign o_overflow  = r_overflow;

endmodule

FILE: hdl/rmma_accum.sv
// Running statistics accumulator: count, sum, min, max and first indices.
// Depends on rmma_pkg.
module rmma_accum import rmma_pkg::*; #(
    parameter int unsigned MAX_ITEMS = 65536,
    parameter int unsigned CNT_W     = 17,
    parameter int unsigned SUM_W     = 33
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_acc_ctl                   i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic [CNT_W-1:0]           o_count,
    output logic signed [SUM_W-1:0]    o_sum,
    output logic signed [SAMPLE_W-1:0] o_min,
    output logic signed [SAMPLE_W-1:0] o_max,
    output logic [CNT_W-1:0]           o_min_idx,
    output logic [CNT_W-1:0]           o_max_idx,
    output logic                       o_too_many
);

    logic [CNT_W-1:0]           r_count;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SAMPLE_W-1:0] r_min;
    logic signed [SAMPLE_W-1:0] r_max;
    logic [CNT_W-1:0]           r_min_idx;
    logic [CNT_W-1:0]           r_max_idx;
    logic                       r_too_many;
    logic                       full;

    assign full = (r_count >= CNT_W'(MAX_ITEMS));

    // Control: count, sum and overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_count    <= '0;
            r_sum      <= '0;
            r_too_many <= 1'b0;
        end else if (i_ctl.fold) begin
            if (full) begin
                r_too_many <= 1'b1;
            end else begin
                r_count <= r_count + CNT_W'(1);
                r_sum   <= r_sum + SUM_W'(i_sample);
            end
        end
    end

    // Extremes and their first indices; strict compares keep the first tie
    always_ff @(posedge i_clk) begin
        if (i_ctl.fold && !full) begin
            if (r_count == '0) begin
                r_min     <= i_sample;
                r_max     <= i_sample;
                r_min_idx <= '0;
                r_max_idx <= '0;
            end else begin
                if (i_sample < r_min) begin
                    r_min     <= i_sample;
                    r_min_idx <= r_count;
                end
                if (i_sample > r_max) begin
                    r_max     <= i_sample;
                    r_max_idx <= r_count;
                end
            end
        end
    end

    assign o_count    = r_count;
    assign o_sum      = r_sum;
    assign o_min      = r_min;
    assign o_max      = r_max;
    assign o_min_idx  = r_min_idx;
    assign o_max_idx  = r_max_idx;
    assign o_too_many = r_too_many;

endmodule

FILE: hdl/rmma_div.sv
// Restoring divider, one quotient bit per cycle through one shared subtractor.
// Depends on rmma_pkg.
module rmma_div import rmma_pkg::*; #(
    parameter int unsigned DIV_W = 41,
    parameter int unsigned CNT_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [CNT_W-1:0] i_divisor,
    output t_div_sts         o_sts,
    output logic [DIV_W-1:0] o_quotient
);

    localparam int unsigned STEP_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  r_q;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;
    logic [CNT_W:0]    rem_shift;
    logic [CNT_W+1:0]  diff;
    logic              ge;

    // Shared subtract and compare
    assign rem_shift = {r_rem, r_q[DIV_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, r_div};
    assign ge        = !diff[CNT_W+1];

    // Sequencer status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= STEP_W'(DIV_W);
        end else if (r_busy) begin
            r_step <= r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Datapath: shift one dividend bit in, subtract when it fits
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_W-2:0], ge};
            r_rem <= ge ? diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_q;

endmodule

FILE: hdl/rmma_checker.sv
// Port-level checks for running_min_max_average, attached by bind.
// Depends on rmma_pkg and the top level's port list.
module rmma_checker import rmma_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic signed [SAMPLE_W-1:0] i_sample,
    input logic                       i_last,
    input logic                       i_empty_set,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic signed [SAMPLE_W-1:0] o_min_value,
    input logic signed [IDX_W-1:0]    o_min_index,
    input logic signed [SAMPLE_W-1:0] o_max_value,
    input logic signed [IDX_W-1:0]    o_max_index,
    input logic signed [AVG_W-1:0]    o_average,
    input logic                       o_overflow
);

    logic in_beat;
    assign in_beat = i_valid && !o_stall;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_average) && $stable(o_min_index)
            && $stable(o_max_index))
        else $error("stalled result beat changed");

    // An empty set yields its fixed result in the next cycle
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_empty_set |=> o_valid && o_min_value == EMPTY_VALUE
            && o_max_value == EMPTY_VALUE && o_min_index == EMPTY_INDEX
            && o_max_index == EMPTY_INDEX && !o_overflow)
        else $error("empty set result wrong");

    // A sample that is neither last nor empty creates no result
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && !i_last && !i_empty_set && !o_valid |=> !o_valid)
        else $error("result without last or empty beat");

    // The division keeps the input stalled after a last sample
    a_div_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_last && !i_empty_set |=> o_stall)
        else $error("input not stalled during division");

    // Minimum never exceeds maximum
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_min_value <= o_max_value)
        else $error("min above max");

endmodule

bind running_min_max_average rmma_checker u_rmma_checker (.*);

FILE: tb/tb.sv
// Self-checking testbench for running_min_max_average: directed table and random sets.
// Result beats are checked against an in-bench model of the running statistics or a fixed row.
// Depends on rmma_pkg and the RTL under hdl/.
module tb;
    import rmma_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_ITEMS      = 65536;
    localparam int unsigned FRAC_BITS      = 8;
    localparam int unsigned CLK_PERIOD     = 10;
    localparam int unsigned RESET_CYCLES   = 12;
    localparam int unsigned RANDOM_BEATS   = 800;
    localparam int unsigned DRAIN_CYCLES   = 60;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned N_ROWS         = 24;

    // One result beat
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] min_value;
        logic signed [IDX_W-1:0]    min_index;
        logic signed [SAMPLE_W-1:0] max_value;
        logic signed [IDX_W-1:0]    max_index;
        logic signed [AVG_W-1:0]    average;
        logic                       overflow;
    } set_stats_t;

    // One row of the directed table; want is used only when fixed is set
    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
        logic                       empty;
        bit                         fixed;
        set_stats_t                 want;
    } stim_row_t;

    localparam logic signed [AVG_W-1:0] EMPTY_AVG =
        $signed(AVG_W'(EMPTY_VALUE)) <<< FRAC_BITS;
    localparam set_stats_t EMPTY_STATS =
        '{EMPTY_VALUE, EMPTY_INDEX, EMPTY_VALUE, EMPTY_INDEX, EMPTY_AVG, 1'b0};
    localparam set_stats_t NO_CHECK = '0;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic signed [SAMPLE_W-1:0] i_sample = '0;
    logic                       i_last = 1'b0;
    logic                       i_empty_set = 1'b0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] o_min_value;
    logic signed [IDX_W-1:0]    o_min_index;
    logic signed [SAMPLE_W-1:0] o_max_value;
    logic signed [IDX_W-1:0]    o_max_index;
    logic signed [AVG_W-1:0]    o_average;
    logic                       o_overflow;

    // Model of the running statistics of the open set
    int unsigned                set_count = 0;
    longint                     set_sum = 0;
    logic signed [SAMPLE_W-1:0] run_min = '0;
    logic signed [SAMPLE_W-1:0] run_max = '0;
    int unsigned                min_at = 0;
    int unsigned                max_at = 0;
    bit                         set_too_many = 1'b0;

    set_stats_t  pending_stats[$];
    int unsigned mismatches = 0;
    int unsigned results_seen = 0;
    int unsigned beats_sent = 0;
    int unsigned idle_cycles = 0;
    bit          sender_calm = 1'b0;
    bit          row_fixed = 1'b0;
    set_stats_t  row_want = '0;

    // Receiver pacing state
    int unsigned stall_left = 0;
    int unsigned mood_left = 0;
    bit          recv_calm = 1'b0;

    stim_row_t dir_rows [N_ROWS] = '{
        // empty set straight out of reset
        '{16'sd0,      1'b0, 1'b1, 1'b1, EMPTY_STATS},
        // single-sample sets at both extremes
        '{16'sd32767,  1'b1, 1'b0, 1'b1,
          '{16'sd32767, 17'sd0, 16'sd32767, 17'sd0, 24'sd8388352, 1'b0}},
        '{-16'sd32768, 1'b1, 1'b0, 1'b1,
          '{-16'sd32768, 17'sd0, -16'sd32768, 17'sd0, -24'sd8388608, 1'b0}},
        // element 0 is the minimum, ties on both extremes keep the first
        '{-16'sd5,     1'b0, 1'b0, 1'b0, NO_CHECK},
        '{16'sd7,      1'b0, 1'b0, 1'b0, NO_CHECK},
        '{16'sd7,      1'b0, 1'b0, 1'b0, NO_CHECK},
        '{-16'sd5,     1'b0, 1'b0, 1'b0, NO_CHECK},
        '{16'sd3,      1'b1, 1'b0, 1'b0, NO_CHECK},
        // empty set discards a partial set and wins over last
        '{16'sd100,    1'b0, 1'b0, 1'b0, NO_CHECK},
        '{16'sd200,    1'b0, 1'b0, 1'b0, NO_CHECK},
        '{-16'sd32768, 1'b1, 1'b1, 1'b1, EMPTY_STATS},
        // state must be clean after the discard
        '{16'sd12345,  1'b1, 1'b0, 1'b1,
          '{16'sd12345, 17'sd0, 16'sd12345, 17'sd0, 24'sd3160320, 1'b0}},
        // negative mean truncates toward zero
        '{-16'sd7,     1'b0, 1'b0, 1'b0, NO_CHECK},
        '{16'sd0,      1'b0, 1'b0, 1'b0, NO_CHECK},
        '{16'sd0,      1'b1, 1'b0, 1'b0, NO_CHECK},
        // alternating extremes
        '{16'sd32767,  1'b0, 1'b0, 1'b0, NO_CHECK},
        '{-16'sd32768, 1'b0, 1'b0, 1'b0, NO_CHECK},
        '{16'sd32767,  1'b0, 1'b0, 1'b0, NO_CHECK},
        '{-16'sd32768, 1'b1, 1'b0, 1'b0, NO_CHECK},
        // empty with last while a set is open, then empty with nothing held
        '{-16'sd1,     1'b0, 1'b0, 1'b0, NO_CHECK},
        '{-16'sd1,     1'b1, 1'b1, 1'b1, EMPTY_STATS},
        '{16'sd0,      1'b0, 1'b1, 1'b1, EMPTY_STATS},
        // fractional mean
        '{16'sd1,      1'b0, 1'b0, 1'b0, NO_CHECK},
        '{16'sd2,      1'b1, 1'b0, 1'b0, NO_CHECK}
    };

    running_min_max_average #(
        .MAX_ITEMS (MAX_ITEMS),
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample    (i_sample),
        .i_last      (i_last),
        .i_empty_set (i_empty_set),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_min_value (o_min_value),
        .o_min_index (o_min_index),
        .o_max_value (o_max_value),
        .o_max_index (o_max_index),
        .o_average   (o_average),
        .o_overflow  (o_overflow)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    wire in_beat  = i_valid && !o_stall;
    wire out_beat = o_valid && !i_stall;

    function automatic void clear_set();
        set_count    = 0;
        set_sum      = 0;
        run_min      = '0;
        run_max      = '0;
        min_at       = 0;
        max_at       = 0;
        set_too_many = 1'b0;
    endfunction

    // Fold one accepted beat into the open set; returns 1 when it closes the set
    function automatic bit fold_sample(input logic signed [SAMPLE_W-1:0] s,
                                       input logic last_in, input logic empty_in,
                                       output set_stats_t res);
        longint unsigned mag;
        longint unsigned quo;
        res = EMPTY_STATS;
        if (empty_in) begin
            clear_set();
            return 1'b1;
        end
        if (set_count >= MAX_ITEMS) begin
            set_too_many = 1'b1;
        end else begin
            if (set_count == 0) begin
                run_min = s;
                run_max = s;
                min_at  = 0;
                max_at  = 0;
            end else begin
                if (s < run_min) begin
                    run_min = s;
                    min_at  = set_count;
                end
                if (s > run_max) begin
                    run_max = s;
                    max_at  = set_count;
                end
            end
            set_sum   += s;
            set_count += 1;
        end
        if (!last_in)
            return 1'b0;
        res.min_value = run_min;
        res.min_index = IDX_W'(min_at);
        res.max_value = run_max;
        res.max_index = IDX_W'(max_at);
        // mean of the magnitude, sign applied after, saturated to 24 bits
        if (set_count == 0) begin
            res.average = '0;
        end else begin
            mag = (set_sum < 0) ? longint'(-set_sum) : longint'(set_sum);
            quo = (mag << FRAC_BITS) / set_count;
            if (set_sum < 0)
                res.average = (quo > AVG_LO_MAG) ? AVG_SAT_LO : AVG_W'(-longint'(quo));
            else
                res.average = (quo > AVG_HI_MAG) ? AVG_SAT_HI : AVG_W'(quo);
        end
        res.overflow = set_too_many;
        clear_set();
        return 1'b1;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Sample mix: extremes, a narrow band that forces ties, full range
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            1, 2: return SAMPLE_W'($urandom_range(0, 8)) - 16'sd4;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    function automatic int unsigned pick_gap();
        if (sender_calm)
            return 0;
        case ($urandom_range(0, 19))
            0: return $urandom_range(10, 40);
            1, 2, 3, 4, 5, 6: return $urandom_range(1, 3);
            default: return 0;
        endcase
    endfunction

    // Drive one sample beat at the falling edge and hold it until accepted
    task automatic send_beat(input logic signed [SAMPLE_W-1:0] s, input logic last_in,
                             input logic empty_in, input bit fixed = 1'b0,
                             input set_stats_t want = '0);
        int unsigned gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample    <= s;
        i_last      <= last_in;
        i_empty_set <= empty_in;
        row_fixed   = fixed;
        row_want    = want;
        do @(posedge i_clk); while (o_stall);
        beats_sent++;
    endtask

    // Hold the sender off until every open result has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
    endtask

    // Receiver stall: calm stretches, short stalls, now and then a long one
    always @(negedge i_clk) begin
        if (mood_left == 0) begin
            mood_left = $urandom_range(16, 256);
            recv_calm = ($urandom_range(0, 3) == 0);
        end else begin
            mood_left--;
        end
        if (stall_left != 0)
            stall_left--;
        else if (!recv_calm && $urandom_range(0, 2) == 0)
            stall_left = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(1, 3);
        i_stall <= (stall_left != 0);
    end

    // Scoreboard: check the result beat first, then log the sample beat
    always @(posedge i_clk) begin
        set_stats_t got;
        set_stats_t want;
        set_stats_t predicted;
        if (i_rst_n) begin
            if (out_beat) begin
                got = '{o_min_value, o_min_index, o_max_value, o_max_index,
                        o_average, o_overflow};
                results_seen++;
                if (pending_stats.size() == 0) begin
                    report_error($sformatf("result %0d arrived with none expected",
                                           results_seen));
                end else begin
                    want = pending_stats.pop_front();
                    if (got.min_value !== want.min_value)
                        report_error($sformatf("result %0d min_value: got %0d, expected %0d",
                                               results_seen, got.min_value, want.min_value));
                    if (got.min_index !== want.min_index)
                        report_error($sformatf("result %0d min_index: got %0d, expected %0d",
                                               results_seen, got.min_index, want.min_index));
                    if (got.max_value !== want.max_value)
                        report_error($sformatf("result %0d max_value: got %0d, expected %0d",
                                               results_seen, got.max_value, want.max_value));
                    if (got.max_index !== want.max_index)
                        report_error($sformatf("result %0d max_index: got %0d, expected %0d",
                                               results_seen, got.max_index, want.max_index));
                    if (got.average !== want.average)
                        report_error($sformatf("result %0d average: got %0d, expected %0d",
                                               results_seen, got.average, want.average));
                    if (got.overflow !== want.overflow)
                        report_error($sformatf("result %0d overflow: got %0b, expected %0b",
                                               results_seen, got.overflow, want.overflow));
                end
            end
            if (in_beat) begin
                if (fold_sample(i_sample, i_last, i_empty_set, predicted))
                    pending_stats.push_back(row_fixed ? row_want : predicted);
            end
        end
    end

    // Watchdog on cycles without any beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || in_beat || out_beat) begin
            idle_cycles <= 0;
        end else if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned set_len;
        int unsigned cut;
        int unsigned set_no;
        bit          broken;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (int r = 0; r < N_ROWS; r++)
            send_beat(dir_rows[r].sample, dir_rows[r].last, dir_rows[r].empty,
                      dir_rows[r].fixed, dir_rows[r].want);
        drain_results();

        // Random sets, a few broken by an empty-set beat, a few stray empty beats
        set_no = 0;
        while (beats_sent < N_ROWS + RANDOM_BEATS) begin
            sender_calm = ($urandom_range(0, 3) == 0);
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 120)
                                                  : $urandom_range(1, 12);
            broken = ($urandom_range(0, 11) == 0);
            cut    = $urandom_range(0, set_len - 1);
            for (int k = 0; k < set_len; k++) begin
                if (broken && k == cut) begin
                    send_beat(pick_sample(), 1'($urandom_range(0, 1)), 1'b1);
                    break;
                end
                send_beat(pick_sample(), k == set_len - 1, 1'b0);
            end
            if ($urandom_range(0, 9) == 0)
                send_beat(pick_sample(), 1'($urandom_range(0, 1)), 1'b1);
            set_no++;
            if (set_no % 40 == 0)
                drain_results();
        end
        sender_calm = 1'b0;
        send_beat(16'sd42, 1'b1, 1'b0);

        // Wait for the last results, then a little longer for strays
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_stats.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/rmma_pkg.sv
hdl/rmma_accum.sv
hdl/rmma_div.sv
hdl/running_min_max_average.sv
hdl/rmma_checker.sv
tb/tb.sv
